>>> hdl/bsl_pkg.sv
package bsl_pkg;

   // Default build values for the top-level parameters.
   localparam int COUNT_BITS_DEF     = 12;
   localparam int DUTY_FRAC_BITS_DEF = 16;

   // Gains are Q0.16.
   localparam int GAIN_FRAC = 16;

   // Port and field widths.
   localparam int HALL_W      = 3;
   localparam int TARGET_W    = 16;
   localparam int DUTY_W      = 8;
   localparam int SPEED_NOW_W = 20;
   localparam int GAIN_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 2;

   // Register values after reset.
   localparam logic [7:0]  PWM_PERIOD_RST    = 8'd100;
   localparam logic [7:0]  RPM_PER_COUNT_RST = 8'd25;
   localparam logic [15:0] KP_RUN_RST        = 16'd367;
   localparam logic [15:0] KP_STOP_RST       = 16'd347;
   localparam logic [15:0] KI_RUN_RST        = 16'd2949;
   localparam logic [15:0] KI_STOP_RST       = 16'd3277;
   localparam logic [15:0] KD_GAIN_RST       = 16'd5898;
   localparam logic [15:0] MAX_ACCEL_RST     = 16'd200;

   // Acceleration is (speed_prev - speed) * ACCEL_NUM / ACCEL_DEN.
   localparam int ACCEL_NUM = 1309;
   localparam int ACCEL_DEN = 1250;

   // Kick start and low-duty cut-off, in whole duty units.
   localparam logic [DUTY_W-1:0] KICK_DUTY = 8'd50;
   localparam int KICK_ACC_WHOLE = 4;
   localparam int MIN_DUTY_WHOLE = 4;

   // Division by twenty: a shift by two, then byte digits divided by five.
   localparam int DIV_PRE_SHIFT   = 2;
   localparam int DIV_FACTOR      = 5;
   localparam int DIV_DIGIT_W     = 8;
   localparam int DIV_RECIP       = 1639;
   localparam int DIV_RECIP_SHIFT = 13;

   typedef enum logic [1:0] {
      REQ_EDGE   = 2'd0,
      REQ_TICK   = 2'd1,
      REQ_TARGET = 2'd2,
      REQ_ESTOP  = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PWM_PERIOD    = 3'd0,
      CSR_RPM_PER_COUNT = 3'd1,
      CSR_KP_RUN        = 3'd2,
      CSR_KP_STOP       = 3'd3,
      CSR_KI_RUN        = 3'd4,
      CSR_KI_STOP       = 3'd5,
      CSR_KD_GAIN       = 3'd6,
      CSR_MAX_ACCEL     = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_EDGE,
      OP_TARGET,
      OP_ESTOP,
      OP_SPEED,
      OP_ERR,
      OP_MUL_P,
      OP_MUL_I,
      OP_ADD_I,
      OP_ADD_D,
      OP_DIV_FLOOR,
      OP_DIV_TRUNC,
      OP_WB_FLOOR,
      OP_WB_TRUNC,
      OP_CLAMP,
      OP_OUT_EDGE,
      OP_OUT_KICK,
      OP_OUT_DUTY
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_I,
      ST_TRUNC1,
      ST_WAIT1,
      ST_ADD_I,
      ST_TRUNC2,
      ST_WAIT2,
      ST_ADD_D,
      ST_FLOOR,
      ST_WAITF,
      ST_CLAMP,
      ST_EDGE_OUT,
      ST_KICK_OUT,
      ST_DUTY_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic kick;
      logic stop;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic                   stop_active;
      logic                   over_accel;
      logic [SPEED_NOW_W-1:0] speed_now;
      logic                   phase_valid;
      logic [HALL_W-1:0]      phase_lines;
      logic                   duty_valid;
      logic [DUTY_W-1:0]      duty_out;
   } rsp_fields_type;

   // Kick-start commutation: returns {valid, lines} for a hall pattern.
   function automatic logic [HALL_W:0] kick_phase(input logic [HALL_W-1:0] hall);
      logic [HALL_W:0] res;
      unique case (hall)
         3'b001:  res = {1'b1, 3'd3};
         3'b010:  res = {1'b1, 3'd6};
         3'b011:  res = {1'b1, 3'd2};
         3'b100:  res = {1'b1, 3'd5};
         3'b101:  res = {1'b1, 3'd1};
         3'b110:  res = {1'b1, 3'd4};
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

>>> hdl/bsl_div20.sv
// Unsigned floor division by twenty. The dividend is shifted right by two
// and the rest is divided by five one byte digit per cycle, most significant
// digit first, with the digit quotient taken from a reciprocal multiply.
module bsl_div20 import bsl_pkg::*; #(
   parameter int IN_W = 56
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [IN_W-1:0] dividend,
   output logic            done,
   output logic [IN_W-1:0] quotient
);

   localparam int NUM_W  = IN_W - DIV_PRE_SHIFT;
   localparam int NDIG   = (NUM_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W;
   localparam int DW     = NDIG * DIV_DIGIT_W;
   localparam int CNT_W  = $clog2(NDIG + 1);
   localparam int REM_W  = 3;
   localparam int V_W    = REM_W + DIV_DIGIT_W;
   localparam int PR_W   = 2 * V_W;

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DW-1:0]    num_ff, num_in;
   logic [DW-1:0]    quo_ff, quo_in;

   logic [V_W-1:0]         step_v;
   logic [PR_W-1:0]        step_prod;
   logic [DIV_DIGIT_W-1:0] step_q;
   logic [V_W-1:0]         step_rem;

   // One digit step: remainder and next digit divided by five.
   always_comb begin
      step_v    = {rem_ff, num_ff[DW-1 -: DIV_DIGIT_W]};
      step_prod = PR_W'(step_v) * PR_W'(DIV_RECIP);
      step_q    = step_prod[DIV_RECIP_SHIFT +: DIV_DIGIT_W];
      step_rem  = step_v - V_W'(step_q) * V_W'(DIV_FACTOR);
   end

   // Sequencing of the digit steps.
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      num_in    = num_ff;
      quo_in    = quo_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(NDIG);
         rem_in    = '0;
         num_in    = DW'(dividend >> DIV_PRE_SHIFT);
      end else if (active_ff) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = step_rem[REM_W-1:0];
         num_in = num_ff << DIV_DIGIT_W;
         quo_in = {quo_ff[DW-DIV_DIGIT_W-1:0], step_q};
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = IN_W'(quo_ff);

endmodule

>>> hdl/bsl_dpath.sv
// Datapath: configuration registers, loop state, one shared gain multiplier,
// a wide accumulator, the divide-by-twenty unit and the result register.
module bsl_dpath import bsl_pkg::*; #(
   parameter int COUNT_BITS     = COUNT_BITS_DEF,
   parameter int DUTY_FRAC_BITS = DUTY_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   input  logic [HALL_W-1:0]     req_hall,
   input  logic [TARGET_W-1:0]   req_target,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output rsp_fields_type        rsp_fields,
   output dp_status_type         status
);

   localparam int SW    = COUNT_BITS + 8;
   localparam int EW    = SW + 1;
   localparam int WF    = (DUTY_FRAC_BITS > GAIN_FRAC) ? DUTY_FRAC_BITS : GAIN_FRAC;
   localparam int SH    = WF - GAIN_FRAC;
   localparam int DSH   = WF - DUTY_FRAC_BITS;
   localparam int XW    = EW + WF + 11;
   localparam int PW    = EW + GAIN_W + 2;
   localparam int DAW   = DUTY_FRAC_BITS + DUTY_W;
   localparam int AW    = SW + 11;

   // Configuration registers.
   logic [7:0]        pwm_ff, pwm_in;
   logic [7:0]        rpm_ff, rpm_in;
   logic [GAIN_W-1:0] kp_run_ff, kp_run_in;
   logic [GAIN_W-1:0] kp_stop_ff, kp_stop_in;
   logic [GAIN_W-1:0] ki_run_ff, ki_run_in;
   logic [GAIN_W-1:0] ki_stop_ff, ki_stop_in;
   logic [GAIN_W-1:0] kd_ff, kd_in;
   logic [GAIN_W-1:0] max_accel_ff, max_accel_in;

   // Loop state.
   logic [COUNT_BITS-1:0] edge_ff, edge_in;
   logic [SW-1:0]         speed_cur_ff, speed_cur_in;
   logic [SW-1:0]         speed_prev_ff, speed_prev_in;
   logic [TARGET_W-1:0]   target_ff, target_in;
   logic signed [EW-1:0]  err_cur_ff, err_cur_in;
   logic signed [EW-1:0]  err_prev_ff, err_prev_in;
   logic [DAW-1:0]        duty_ff, duty_in;
   logic                  stop_ff, stop_in;

   // Working registers.
   logic                 over_ff, over_in;
   logic [HALL_W-1:0]    hall_ff, hall_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [XW-1:0] acc_ff, acc_in;
   logic                 neg_ff, neg_in;

   // Result register.
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_fields_type rsp_ff, rsp_in;

   // Intermediate values.
   logic signed [GAIN_W:0] mul_a;
   logic signed [EW:0]     mul_b;
   logic signed [EW:0]     err_sum;
   logic signed [EW:0]     err_diff;
   logic signed [XW-1:0]   prod_x;
   logic signed [XW-1:0]   p_term;
   logic signed [XW-1:0]   i_term;
   logic signed [XW-1:0]   d_term;
   logic signed [XW-1:0]   duty_x;
   logic signed [XW-1:0]   x0_term;
   logic signed [SW:0]     speed_diff;
   logic [SW-1:0]          speed_mag;
   logic [AW-1:0]          accel_lhs;
   logic [AW-1:0]          accel_rhs;
   logic [XW-1:0]          div_mag;
   logic                   div_start;
   logic                   div_done;
   logic [XW-1:0]          div_q;
   logic signed [XW-1:0]   floor_q;
   logic [XW-1:0]          whole_q;
   logic [XW-1:0]          whole_u;
   logic signed [XW-1:0]   duty_lim;
   logic signed [XW-1:0]   duty_min;
   logic signed [XW-1:0]   clamp_v;
   logic [HALL_W:0]        kick_ph;
   logic                   rsp_free;

   // Error sum and difference feed the trapezoid and difference terms.
   always_comb begin
      err_sum  = (EW+1)'(err_prev_ff) + (EW+1)'(err_cur_ff);
      err_diff = (EW+1)'(err_cur_ff) - (EW+1)'(err_prev_ff);
   end

   // Shared multiplier operands: proportional, trapezoid, then difference.
   always_comb begin
      mul_a = $signed({1'b0, kd_ff});
      mul_b = err_diff;
      priority if (cmd.op == OP_MUL_P) begin
         mul_a = $signed({1'b0, stop_ff ? kp_stop_ff : kp_run_ff});
         mul_b = (EW+1)'(err_cur_ff);
      end else if (cmd.op == OP_MUL_I) begin
         mul_a = $signed({1'b0, stop_ff ? ki_stop_ff : ki_run_ff});
         mul_b = err_sum;
      end else begin
         mul_a = $signed({1'b0, kd_ff});
         mul_b = err_diff;
      end
   end

   // Terms in units of one twentieth of the working fraction; the constant
   // factors twenty and two hundred are built from shifts and adds.
   always_comb begin
      prod_x  = XW'(prod_ff);
      p_term  = ((prod_x <<< 4) + (prod_x <<< 2)) <<< SH;
      i_term  = prod_x <<< SH;
      d_term  = ((prod_x <<< 7) + (prod_x <<< 6) + (prod_x <<< 3)) <<< SH;
      duty_x  = $signed(XW'(duty_ff));
      x0_term = ((duty_x <<< 4) + (duty_x <<< 2)) <<< DSH;
   end

   // Over-acceleration test on the magnitude, without a divide.
   always_comb begin
      speed_diff = $signed({1'b0, speed_prev_ff}) - $signed({1'b0, speed_cur_ff});
      speed_mag  = speed_diff[SW] ? SW'(-speed_diff) : SW'(speed_diff);
      accel_lhs  = AW'(speed_mag) * AW'(ACCEL_NUM);
      accel_rhs  = AW'(max_accel_ff) * AW'(ACCEL_DEN);
   end

   // Divider operand: one's complement for floor, negation for truncation.
   always_comb begin
      div_start = (cmd.op == OP_DIV_FLOOR) || (cmd.op == OP_DIV_TRUNC);
      if (!acc_ff[XW-1]) begin
         div_mag = acc_ff;
      end else if (cmd.op == OP_DIV_FLOOR) begin
         div_mag = ~acc_ff;
      end else begin
         div_mag = -acc_ff;
      end
   end

   bsl_div20 #(
      .IN_W (XW)
   ) u_div20 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   // Divider write-back values and clamp limits.
   always_comb begin
      floor_q  = neg_ff ? ~$signed(div_q) : $signed(div_q);
      whole_q  = div_q >> WF;
      whole_u  = ((whole_q << 4) + (whole_q << 2)) << WF;
      duty_lim = $signed(XW'(pwm_ff) << DUTY_FRAC_BITS);
      duty_min = $signed(XW'(MIN_DUTY_WHOLE) << DUTY_FRAC_BITS);
      if (acc_ff[XW-1]) begin
         clamp_v = '0;
      end else if (acc_ff > duty_lim) begin
         clamp_v = duty_lim;
      end else begin
         clamp_v = acc_ff;
      end
      if ((clamp_v < duty_min) && (target_ff == '0)) begin
         clamp_v = '0;
      end
      kick_ph = kick_phase(hall_ff);
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Next-state logic for configuration, state and working registers.
   always_comb begin
      pwm_in        = pwm_ff;
      rpm_in        = rpm_ff;
      kp_run_in     = kp_run_ff;
      kp_stop_in    = kp_stop_ff;
      ki_run_in     = ki_run_ff;
      ki_stop_in    = ki_stop_ff;
      kd_in         = kd_ff;
      max_accel_in  = max_accel_ff;
      edge_in       = edge_ff;
      speed_cur_in  = speed_cur_ff;
      speed_prev_in = speed_prev_ff;
      target_in     = target_ff;
      err_cur_in    = err_cur_ff;
      err_prev_in   = err_prev_ff;
      duty_in       = duty_ff;
      stop_in       = stop_ff;
      over_in       = over_ff;
      hall_in       = cmd.capture ? req_hall : hall_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      neg_in        = div_start ? acc_ff[XW-1] : neg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;

      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_PWM_PERIOD:    pwm_in       = csr_wdata[7:0];
            CSR_RPM_PER_COUNT: rpm_in       = csr_wdata[7:0];
            CSR_KP_RUN:        kp_run_in    = csr_wdata;
            CSR_KP_STOP:       kp_stop_in   = csr_wdata;
            CSR_KI_RUN:        ki_run_in    = csr_wdata;
            CSR_KI_STOP:       ki_stop_in   = csr_wdata;
            CSR_KD_GAIN:       kd_in        = csr_wdata;
            CSR_MAX_ACCEL:     max_accel_in = csr_wdata;
            default:           pwm_in       = pwm_ff;
         endcase
      end

      unique case (cmd.op)
         OP_EDGE: begin
            if (edge_ff != '1) begin
               edge_in = edge_ff + 1'b1;
            end
         end
         OP_TARGET: begin
            if (!stop_ff) begin
               target_in = req_target;
            end
         end
         OP_ESTOP: begin
            target_in = '0;
            stop_in   = 1'b1;
         end
         OP_SPEED: begin
            speed_prev_in = speed_cur_ff;
            err_prev_in   = err_cur_ff;
            speed_cur_in  = SW'(edge_ff) * SW'(rpm_ff);
            edge_in       = '0;
         end
         OP_ERR: begin
            err_cur_in = $signed(EW'(target_ff)) - $signed(EW'(speed_cur_ff));
            over_in    = accel_lhs >= accel_rhs;
         end
         OP_MUL_P: begin
            prod_in = mul_a * mul_b;
            acc_in  = x0_term;
         end
         OP_MUL_I: begin
            prod_in = mul_a * mul_b;
            acc_in  = acc_ff + p_term;
         end
         OP_ADD_I: begin
            prod_in = mul_a * mul_b;
            acc_in  = acc_ff - i_term;
         end
         OP_ADD_D: begin
            acc_in = acc_ff - d_term;
         end
         OP_WB_FLOOR: begin
            acc_in = floor_q >>> DSH;
         end
         OP_WB_TRUNC: begin
            acc_in = neg_ff ? -$signed(whole_u) : $signed(whole_u);
         end
         OP_CLAMP: begin
            duty_in = DAW'(clamp_v);
            if (stop_ff && (speed_cur_ff == '0)) begin
               stop_in = 1'b0;
            end
         end
         OP_OUT_EDGE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.duty_out    = '0;
            rsp_in.duty_valid  = 1'b0;
            rsp_in.phase_lines = hall_ff;
            rsp_in.phase_valid = 1'b1;
            rsp_in.speed_now   = SPEED_NOW_W'(speed_cur_ff);
            rsp_in.over_accel  = 1'b0;
            rsp_in.stop_active = stop_ff;
         end
         OP_OUT_KICK: begin
            duty_in            = DAW'(KICK_ACC_WHOLE) << DUTY_FRAC_BITS;
            rsp_valid_in       = 1'b1;
            rsp_in.duty_out    = KICK_DUTY;
            rsp_in.duty_valid  = 1'b1;
            rsp_in.phase_lines = kick_ph[HALL_W-1:0];
            rsp_in.phase_valid = kick_ph[HALL_W];
            rsp_in.speed_now   = SPEED_NOW_W'(speed_cur_ff);
            rsp_in.over_accel  = over_ff;
            rsp_in.stop_active = stop_ff;
         end
         OP_OUT_DUTY: begin
            rsp_valid_in       = 1'b1;
            rsp_in.duty_out    = duty_ff[DUTY_FRAC_BITS +: DUTY_W];
            rsp_in.duty_valid  = 1'b1;
            rsp_in.phase_lines = '0;
            rsp_in.phase_valid = 1'b0;
            rsp_in.speed_now   = SPEED_NOW_W'(speed_cur_ff);
            rsp_in.over_accel  = over_ff;
            rsp_in.stop_active = stop_ff;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Configuration set to its defaults and loop state cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_ff        <= PWM_PERIOD_RST;
         rpm_ff        <= RPM_PER_COUNT_RST;
         kp_run_ff     <= KP_RUN_RST;
         kp_stop_ff    <= KP_STOP_RST;
         ki_run_ff     <= KI_RUN_RST;
         ki_stop_ff    <= KI_STOP_RST;
         kd_ff         <= KD_GAIN_RST;
         max_accel_ff  <= MAX_ACCEL_RST;
         edge_ff       <= '0;
         speed_cur_ff  <= '0;
         speed_prev_ff <= '0;
         target_ff     <= '0;
         err_cur_ff    <= '0;
         err_prev_ff   <= '0;
         duty_ff       <= '0;
         stop_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pwm_ff        <= pwm_in;
         rpm_ff        <= rpm_in;
         kp_run_ff     <= kp_run_in;
         kp_stop_ff    <= kp_stop_in;
         ki_run_ff     <= ki_run_in;
         ki_stop_ff    <= ki_stop_in;
         kd_ff         <= kd_in;
         max_accel_ff  <= max_accel_in;
         edge_ff       <= edge_in;
         speed_cur_ff  <= speed_cur_in;
         speed_prev_ff <= speed_prev_in;
         target_ff     <= target_in;
         err_cur_ff    <= err_cur_in;
         err_prev_ff   <= err_prev_in;
         duty_ff       <= duty_in;
         stop_ff       <= stop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      over_ff <= over_in;
      hall_ff <= hall_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_fields      = rsp_ff;
   assign status.div_done = div_done;
   assign status.kick     = (speed_cur_ff == '0) && (target_ff != '0);
   assign status.stop     = stop_ff;
   assign status.rsp_free = rsp_free;

endmodule

>>> hdl/bsl_ctrl.sv
// Controller: walks one request through the datapath and decides when the
// result register may be loaded.
module bsl_ctrl import bsl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic [REQ_TUSER_W-1:0] req_type,
   output logic                   req_tready,
   input  dp_status_type          status,
   output dp_cmd_type             cmd
);

   ctrl_state_type state_ff, state_in;
   req_kind_type   kind;

   assign kind = req_kind_type'(req_type);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               unique case (kind)
                  REQ_EDGE: state_in = ST_EDGE_OUT;
                  REQ_TICK: state_in = ST_ERR;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ERR:    state_in = status.kick ? ST_KICK_OUT : ST_MUL_P;
         ST_MUL_P:  state_in = ST_MUL_I;
         ST_MUL_I:  state_in = status.stop ? ST_TRUNC1 : ST_ADD_I;
         ST_TRUNC1: state_in = ST_WAIT1;
         ST_WAIT1:  state_in = status.div_done ? ST_ADD_I : ST_WAIT1;
         ST_ADD_I:  state_in = status.stop ? ST_TRUNC2 : ST_ADD_D;
         ST_TRUNC2: state_in = ST_WAIT2;
         ST_WAIT2:  state_in = status.div_done ? ST_ADD_D : ST_WAIT2;
         ST_ADD_D:  state_in = ST_FLOOR;
         ST_FLOOR:  state_in = ST_WAITF;
         ST_WAITF:  state_in = status.div_done ? ST_CLAMP : ST_WAITF;
         ST_CLAMP:  state_in = ST_DUTY_OUT;
         ST_EDGE_OUT, ST_KICK_OUT, ST_DUTY_OUT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               unique case (kind)
                  REQ_EDGE:   cmd.op = OP_EDGE;
                  REQ_TICK:   cmd.op = OP_SPEED;
                  REQ_TARGET: cmd.op = OP_TARGET;
                  REQ_ESTOP:  cmd.op = OP_ESTOP;
                  default:    cmd.op = OP_NONE;
               endcase
            end
         end
         ST_ERR:      cmd.op = OP_ERR;
         ST_MUL_P:    cmd.op = OP_MUL_P;
         ST_MUL_I:    cmd.op = OP_MUL_I;
         ST_TRUNC1:   cmd.op = OP_DIV_TRUNC;
         ST_WAIT1:    cmd.op = status.div_done ? OP_WB_TRUNC : OP_NONE;
         ST_ADD_I:    cmd.op = OP_ADD_I;
         ST_TRUNC2:   cmd.op = OP_DIV_TRUNC;
         ST_WAIT2:    cmd.op = status.div_done ? OP_WB_TRUNC : OP_NONE;
         ST_ADD_D:    cmd.op = OP_ADD_D;
         ST_FLOOR:    cmd.op = OP_DIV_FLOOR;
         ST_WAITF:    cmd.op = status.div_done ? OP_WB_FLOOR : OP_NONE;
         ST_CLAMP:    cmd.op = OP_CLAMP;
         ST_EDGE_OUT: cmd.op = status.rsp_free ? OP_OUT_EDGE : OP_NONE;
         ST_KICK_OUT: cmd.op = status.rsp_free ? OP_OUT_KICK : OP_NONE;
         ST_DUTY_OUT: cmd.op = status.rsp_free ? OP_OUT_DUTY : OP_NONE;
         default:     cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/bldc_speed_loop_core.sv
// Set-target and emergency-stop requests give no result.
// A hall edge gives one result; a tick gives one result, by kick start or by the loop.
// A normal tick runs the divide-by-twenty unit, ND = ceil((COUNT_BITS + max(16, DUTY_FRAC_BITS) + 18) / 8)
// byte steps (ND = 6 by default); stop mode runs that unit twice more.
// One request is worked on at a time; the next is taken once the result is registered.
// Synchronous active-high reset restores register defaults and clears all loop state.
module bldc_speed_loop_core import bsl_pkg::*; #(
   parameter int COUNT_BITS     = COUNT_BITS_DEF,
   parameter int DUTY_FRAC_BITS = DUTY_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // hall_state, target_rpm
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // duty_out, phase_lines, speed_now, over_accel, stop_active
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // duty_valid, phase_valid
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type     cmd;
   dp_status_type  status;
   rsp_fields_type fields;

   bsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_type   (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bsl_dpath #(
      .COUNT_BITS     (COUNT_BITS),
      .DUTY_FRAC_BITS (DUTY_FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_hall   (req_tdata[HALL_W-1:0]),
      .req_target (req_tdata[HALL_W +: TARGET_W]),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_fields (fields),
      .status     (status)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = RSP_TDATA_W'({fields.stop_active, fields.over_accel, fields.speed_now,
                                    fields.phase_lines, fields.duty_out});
   assign rsp_tuser = {fields.phase_valid, fields.duty_valid};

endmodule

>>> hdl/bsl_checker.sv
// Port-level checks on the speed loop.
module bsl_checker import bsl_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // No result is pending straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Hall edges and ticks keep the block busy after they are taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == REQ_EDGE || req_tuser == REQ_TICK)
      |=> !req_tready)
      else $error("request taken while busy");

   // Set-target and stop requests never raise a result.
   a_no_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid
      && (req_tuser == REQ_TARGET || req_tuser == REQ_ESTOP) |=> !rsp_tvalid)
      else $error("result raised without a hall edge or tick");

   // A hall edge whose result slot comes free shows its levels in the registered result.
   a_edge_result: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == REQ_EDGE) ##1 (!rsp_tvalid || rsp_tready)
      |=> rsp_tvalid && rsp_tuser[1] && !rsp_tuser[0]
          && rsp_tdata[10:8] == $past(req_tdata[2:0], 2))
      else $error("hall edge result wrong");

endmodule

bind bldc_speed_loop_core bsl_checker u_bsl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> bench/bldc_speed_loop_checker.sv
module bldc_speed_loop_checker import bsl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // hall_state, target_rpm
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // req_type
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // duty_out, phase_lines, speed_now, over_accel, stop_active
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser,  // duty_valid, phase_valid
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatches,
   output int                     awaiting
);

   // Loop terms are carried in units of 1 / (20 * 2^WORK_FRAC).
   localparam int WORK_FRAC =
      (DUTY_FRAC_BITS_DEF > GAIN_FRAC) ? DUTY_FRAC_BITS_DEF : GAIN_FRAC;
   localparam longint ONE_DUTY   = longint'(1) << DUTY_FRAC_BITS_DEF;
   localparam longint DUTY_FINE  = longint'(20) << (WORK_FRAC - DUTY_FRAC_BITS_DEF);
   localparam longint GAIN_ONE   = longint'(1) << (WORK_FRAC - GAIN_FRAC);
   localparam longint GAIN_FINE  = longint'(20) << (WORK_FRAC - GAIN_FRAC);
   localparam longint WHOLE_FINE = longint'(20) << WORK_FRAC;
   // The difference term is ten times the gain, expressed in twentieths.
   localparam longint DIFF_WEIGHT = 200;

   // Register copies.
   logic [7:0]  pwm_period, rpm_per_count;
   logic [15:0] kp_run, kp_stop, ki_run, ki_stop, kd_gain, max_accel;

   // Loop state.
   logic [COUNT_BITS_DEF-1:0] edge_total;
   longint speed_cur, speed_prev, target_speed, err_cur, err_prev, duty_acc;
   logic stop_latch;

   rsp_fields_type report_due[$];
   rsp_fields_type due;
   int fail_total = 0;

   task automatic flag_mismatch(input string what, input longint seen, input longint wanted);
      fail_total++;
      $display("mismatch in %s: got %0d, predicted %0d", what, seen, wanted);
   endtask

   // Applies one accepted request to the loop and queues the response it causes.
   task automatic advance_speed_loop(input req_kind_type kind, input logic [HALL_W-1:0] hall,
                                     input logic [TARGET_W-1:0] tgt);
      rsp_fields_type rec;
      longint accel, prop, trap, diff, acc;
      rec = '0;
      case (kind)
         REQ_EDGE: begin
            if (edge_total != '1)
               edge_total = edge_total + 1'b1;
            rec.phase_lines = hall;
            rec.phase_valid = 1'b1;
            rec.speed_now   = speed_cur[SPEED_NOW_W-1:0];
            rec.stop_active = stop_latch;
            report_due.push_back(rec);
         end
         REQ_TARGET: begin
            if (!stop_latch)
               target_speed = longint'(tgt);
         end
         REQ_ESTOP: begin
            target_speed = 0;
            stop_latch   = 1'b1;
         end
         default: begin
            // Control tick: measure speed, error and acceleration first.
            speed_prev = speed_cur;
            err_prev   = err_cur;
            speed_cur  = longint'(edge_total) * longint'(rpm_per_count);
            err_cur    = target_speed - speed_cur;
            edge_total = '0;
            accel = (speed_prev - speed_cur) * ACCEL_NUM / ACCEL_DEN;
            rec.over_accel = ((accel < 0) ? -accel : accel) >= longint'(max_accel);
            rec.duty_valid = 1'b1;
            if (speed_cur == 0 && target_speed != 0) begin
               // Kick start: fixed duty and commutation straight from the hall levels.
               duty_acc = KICK_ACC_WHOLE * ONE_DUTY;
               rec.duty_out = KICK_DUTY;
               case (hall)
                  3'b001: rec.phase_lines = 3'd3;
                  3'b011: rec.phase_lines = 3'd2;
                  3'b010: rec.phase_lines = 3'd6;
                  3'b110: rec.phase_lines = 3'd4;
                  3'b100: rec.phase_lines = 3'd5;
                  3'b101: rec.phase_lines = 3'd1;
                  default: rec.phase_lines = 3'd0;
               endcase
               rec.phase_valid = (hall != 3'b000) && (hall != 3'b111);
            end else begin
               prop = longint'(stop_latch ? kp_stop : kp_run) * err_cur * GAIN_FINE;
               trap = longint'(stop_latch ? ki_stop : ki_run) * (err_prev + err_cur) * GAIN_ONE;
               diff = longint'(kd_gain) * DIFF_WEIGHT * (err_cur - err_prev) * GAIN_ONE;
               acc  = duty_acc * DUTY_FINE;
               // Stop mode drops the fraction after each of the first two steps.
               if (stop_latch) begin
                  acc = ((acc + prop) / WHOLE_FINE) * WHOLE_FINE;
                  acc = ((acc - trap) / WHOLE_FINE) * WHOLE_FINE;
                  acc = acc - diff;
               end else begin
                  acc = acc + prop - trap - diff;
               end
               duty_acc = acc / DUTY_FINE;
               if (acc % DUTY_FINE != 0 && acc < 0)
                  duty_acc--;
               // Clamps, then the low-duty cut-off when no speed is asked for.
               if (duty_acc < 0)
                  duty_acc = 0;
               if (duty_acc > longint'(pwm_period) * ONE_DUTY)
                  duty_acc = longint'(pwm_period) * ONE_DUTY;
               if (duty_acc < MIN_DUTY_WHOLE * ONE_DUTY && target_speed == 0)
                  duty_acc = 0;
               if (stop_latch && speed_cur == 0)
                  stop_latch = 1'b0;
               rec.duty_out = DUTY_W'(duty_acc >> DUTY_FRAC_BITS_DEF);
            end
            rec.speed_now   = speed_cur[SPEED_NOW_W-1:0];
            rec.stop_active = stop_latch;
            report_due.push_back(rec);
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pwm_period    = PWM_PERIOD_RST;
         rpm_per_count = RPM_PER_COUNT_RST;
         kp_run        = KP_RUN_RST;
         kp_stop       = KP_STOP_RST;
         ki_run        = KI_RUN_RST;
         ki_stop       = KI_STOP_RST;
         kd_gain       = KD_GAIN_RST;
         max_accel     = MAX_ACCEL_RST;
         edge_total    = '0;
         speed_cur     = 0;
         speed_prev    = 0;
         target_speed  = 0;
         err_cur       = 0;
         err_prev      = 0;
         duty_acc      = 0;
         stop_latch    = 1'b0;
         report_due.delete();
      end else begin
         // Register writes, masked to each register's width.
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_PWM_PERIOD:    pwm_period    = csr_wdata[7:0];
               CSR_RPM_PER_COUNT: rpm_per_count = csr_wdata[7:0];
               CSR_KP_RUN:        kp_run        = csr_wdata;
               CSR_KP_STOP:       kp_stop       = csr_wdata;
               CSR_KI_RUN:        ki_run        = csr_wdata;
               CSR_KI_STOP:       ki_stop       = csr_wdata;
               CSR_KD_GAIN:       kd_gain       = csr_wdata;
               CSR_MAX_ACCEL:     max_accel     = csr_wdata;
            endcase
         end

         // A response always belongs to an older request, so it is compared first.
         // Layout: tdata duty[7:0] phase[10:8] speed[30:11] accel[31] stop[32];
         // tuser duty_valid[0] phase_valid[1].
         if (rsp_tvalid && rsp_tready) begin
            if (report_due.size() == 0) begin
               flag_mismatch("response with nothing outstanding", longint'(rsp_tdata), 0);
            end else begin
               due = report_due.pop_front();
               if (rsp_tdata[7:0] !== due.duty_out)
                  flag_mismatch("duty_out", longint'(rsp_tdata[7:0]),
                                longint'(due.duty_out));
               if (rsp_tuser[0] !== due.duty_valid)
                  flag_mismatch("duty_valid", longint'(rsp_tuser[0]),
                                longint'(due.duty_valid));
               if (rsp_tdata[10:8] !== due.phase_lines)
                  flag_mismatch("phase_lines", longint'(rsp_tdata[10:8]),
                                longint'(due.phase_lines));
               if (rsp_tuser[1] !== due.phase_valid)
                  flag_mismatch("phase_valid", longint'(rsp_tuser[1]),
                                longint'(due.phase_valid));
               if (rsp_tdata[30:11] !== due.speed_now)
                  flag_mismatch("speed_now", longint'(rsp_tdata[30:11]),
                                longint'(due.speed_now));
               if (rsp_tdata[31] !== due.over_accel)
                  flag_mismatch("over_accel", longint'(rsp_tdata[31]),
                                longint'(due.over_accel));
               if (rsp_tdata[32] !== due.stop_active)
                  flag_mismatch("stop_active", longint'(rsp_tdata[32]),
                                longint'(due.stop_active));
            end
         end

         if (req_tvalid && req_tready)
            advance_speed_loop(req_kind_type'(req_tuser), req_tdata[2:0], req_tdata[18:3]);
      end
      mismatches <= fail_total;
      awaiting   <= report_due.size();
   end

endmodule

>>> bench/bldc_speed_loop_core_tb.sv
module bldc_speed_loop_core_tb;
   import bsl_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int PHASES        = 6;
   localparam int RANDOM_ITEMS  = 1650;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [REQ_TUSER_W-1:0] req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_wr_en;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int mismatches;
   int awaiting;
   int cycle_count = 0;
   int cur_rpm = int'(RPM_PER_COUNT_RST);
   bit calm = 1'b0;

   bldc_speed_loop_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bldc_speed_loop_checker loop_watch (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response back-pressure: random stall bursts until the final phase.
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Presents one request, sometimes after an idle burst, and waits for its handshake.
   task automatic send_request(input req_kind_type kind, input logic [HALL_W-1:0] hall,
                               input logic [TARGET_W-1:0] tgt);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W - HALL_W - TARGET_W){1'b0}}, tgt, hall};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_edges(input int count);
      for (int i = 0; i < count; i++)
         send_request(REQ_EDGE, 3'($urandom), 16'($urandom));
   endtask

   // Lets the block drain every outstanding response and settle before going on.
   task automatic drain_block;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all eight registers for one phase of the run.
   task automatic load_settings(input int phase);
      logic [CSR_DATA_W-1:0] vals [8];
      case (phase)
         1: begin
            vals[CSR_PWM_PERIOD]    = 16'd255;
            vals[CSR_RPM_PER_COUNT] = 16'd255;
            vals[CSR_KP_RUN]        = 16'hFFFF;
            vals[CSR_KP_STOP]       = 16'hFFFF;
            vals[CSR_KI_RUN]        = 16'hFFFF;
            vals[CSR_KI_STOP]       = 16'hFFFF;
            vals[CSR_KD_GAIN]       = 16'hFFFF;
            vals[CSR_MAX_ACCEL]     = 16'd0;
         end
         2: begin
            vals[CSR_PWM_PERIOD]    = 16'd0;
            vals[CSR_RPM_PER_COUNT] = 16'd1;
            vals[CSR_KP_RUN]        = 16'd0;
            vals[CSR_KP_STOP]       = 16'd0;
            vals[CSR_KI_RUN]        = 16'd0;
            vals[CSR_KI_STOP]       = 16'd0;
            vals[CSR_KD_GAIN]       = 16'd0;
            vals[CSR_MAX_ACCEL]     = 16'hFFFF;
         end
         3: begin
            vals[CSR_PWM_PERIOD]    = {8'h00, PWM_PERIOD_RST};
            vals[CSR_RPM_PER_COUNT] = {8'h00, RPM_PER_COUNT_RST};
            vals[CSR_KP_RUN]        = KP_RUN_RST;
            vals[CSR_KP_STOP]       = KP_STOP_RST;
            vals[CSR_KI_RUN]        = KI_RUN_RST;
            vals[CSR_KI_STOP]       = KI_STOP_RST;
            vals[CSR_KD_GAIN]       = KD_GAIN_RST;
            vals[CSR_MAX_ACCEL]     = MAX_ACCEL_RST;
         end
         default: begin
            // Random settings; the upper byte of the narrow registers is junk to be masked.
            vals[CSR_PWM_PERIOD]    = {8'($urandom), 8'($urandom_range(1, 255))};
            vals[CSR_RPM_PER_COUNT] = {8'($urandom), 8'($urandom_range(0, 1) ?
                                      $urandom_range(1, 40) : $urandom_range(1, 255))};
            vals[CSR_KP_RUN]        = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            vals[CSR_KP_STOP]       = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            vals[CSR_KI_RUN]        = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            vals[CSR_KI_STOP]       = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            vals[CSR_KD_GAIN]       = 16'($urandom_range(0, 65535) >> $urandom_range(0, 12));
            vals[CSR_MAX_ACCEL]     = 16'($urandom_range(0, 65535) >> $urandom_range(4, 16));
         end
      endcase
      for (int i = 0; i < 8; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      cur_rpm = int'(vals[CSR_RPM_PER_COUNT][7:0]);
   endtask

   // Random traffic, mostly whole control sequences with random content.
   task automatic drive_traffic(input int quota);
      int sent;
      int pick;
      int edges;
      logic [TARGET_W-1:0] tgt;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 9);
         if (pick <= 5) begin
            // New target, then a few ticks with edge counts near that speed.
            tgt = 16'($urandom_range(0, 65535) >> $urandom_range(0, 10));
            if ($urandom_range(0, 7) == 0)
               tgt = '0;
            send_request(REQ_TARGET, 3'($urandom), tgt);
            sent++;
            for (int t = $urandom_range(1, 6); t > 0; t--) begin
               edges = int'(tgt) / cur_rpm + $urandom_range(0, 6) - 3;
               if (edges < 0)
                  edges = 0;
               if (edges > 24)
                  edges = $urandom_range(16, 24);
               if ($urandom_range(0, 3) == 0)
                  edges = $urandom_range(0, 40);
               send_edges(edges);
               send_request(REQ_TICK, 3'($urandom), 16'($urandom));
               sent += edges + 1;
            end
         end else if (pick <= 7) begin
            // Emergency stop, ticks while slowing down, then a tick at standstill.
            send_request(REQ_ESTOP, 3'($urandom), 16'($urandom));
            sent++;
            if ($urandom_range(0, 1))
               send_request(REQ_TARGET, 3'($urandom), 16'($urandom));
            for (int t = $urandom_range(0, 3); t > 0; t--) begin
               edges = $urandom_range(0, 12);
               send_edges(edges);
               send_request(REQ_TICK, 3'($urandom), 16'($urandom));
               sent += edges + 1;
            end
            send_request(REQ_TICK, 3'($urandom), 16'($urandom));
            sent++;
         end else begin
            // Noise: any request in any order.
            for (int n = $urandom_range(1, 8); n > 0; n--) begin
               send_request(req_kind_type'($urandom_range(0, 3)), 3'($urandom),
                            16'($urandom));
               sent++;
            end
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset settings.
      send_request(REQ_EDGE, 3'b000, 16'h0000);
      send_request(REQ_EDGE, 3'b111, 16'hFFFF);
      send_request(REQ_TICK, 3'b000, 16'h0000);
      send_request(REQ_TARGET, 3'b000, 16'hFFFF);
      // Kick start for every hall pattern, the two invalid ones among them.
      for (int h = 0; h < 8; h++)
         send_request(REQ_TICK, 3'(h), 16'h0000);
      send_edges(4);
      send_request(REQ_TICK, 3'b101, 16'h0000);
      // Emergency stop; a new target during it is dropped.
      send_request(REQ_ESTOP, 3'b000, 16'h0000);
      send_request(REQ_TARGET, 3'b010, 16'h5555);
      send_edges(2);
      send_request(REQ_TICK, 3'b001, 16'h0000);
      send_request(REQ_TICK, 3'b001, 16'h0000);
      send_request(REQ_TARGET, 3'b101, 16'hAAAA);
      send_request(REQ_TICK, 3'b110, 16'h0000);
      drain_block();

      for (int phase = 1; phase <= PHASES; phase++) begin
         load_settings(phase);
         calm = (phase == PHASES);
         drive_traffic(RANDOM_ITEMS / PHASES);
         drain_block();
      end

      if (mismatches == 0 && awaiting == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
